// ----- rtl/pvc_pkg.sv -----
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types and constants of the polygon convexity / area / centroid core.
// ----------------------------------------------------------------------------
package pvc_pkg;

    localparam int COORD_BITS = 16;
    localparam int SUM_W      = 20;
    localparam int SHOE_W     = 37;
    localparam int AREA_W     = 36;
    localparam int NCNT_W     = 4;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int TPROD_W    = 2 * DIFF_W;
    localparam int TURN_W     = TPROD_W + 1;
    localparam int SPROD_W    = 2 * COORD_BITS;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_ACC,
        OP_CLOSE,
        OP_ERR
    } t_op;

    typedef enum logic [2:0] {
        BS_RUN,
        BS_C1,
        BS_C2,
        BS_DRAIN,
        BS_DIV,
        BS_OUT
    } t_bstate;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic               is_last;
    } t_vertex;

    typedef struct packed {
        t_status            status;
        logic               is_convex;
        logic [35:0]        double_area;
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
    } t_result;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    // one queue entry per vertex that needs work in the back part
    typedef struct packed {
        t_op                     op;
        t_status                 status;
        logic                    do_turn;
        logic                    do_shoe;
        t_point                  pa;
        t_point                  pb;
        t_point                  pv;
        t_point                  f0;
        t_point                  f1;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic [NCNT_W-1:0]       n;
    } t_cmd;

    typedef struct packed {
        logic   valid;
        t_point a;
        t_point b;
        t_point c;
        logic   do_turn;
        logic   do_shoe;
        logic   is_t0;
    } t_uop;

    function automatic logic signed [DIFF_W-1:0] diff_of(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        return {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    endfunction

endpackage

// ----- rtl/pvc_queue.sv -----
// ----------------------------------------------------------------------------
// pvc_queue
// Short command queue between the vertex front part and the arithmetic back.
// ----------------------------------------------------------------------------
module pvc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pvc_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pvc_pkg::t_cmd o_data
);
    import pvc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_en) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/pvc_front.sv -----
// ----------------------------------------------------------------------------
// pvc_front
// Vertex intake: tracks first and recent vertices, count and coordinate sums,
// and turns each later in-range vertex and each closing one into a command.
// ----------------------------------------------------------------------------
module pvc_front #(
    parameter int MAX_VERTICES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pvc_pkg::t_vertex i_vertex,
    output logic             o_full,
    output logic             o_q_push,
    output pvc_pkg::t_cmd    o_q_cmd,
    input  logic             i_q_full
);
    import pvc_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 2);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_VERTICES);

    logic [CNT_W-1:0]        r_count, n_count;
    t_point                  r_f0, n_f0;
    t_point                  r_f1, n_f1;
    t_point                  r_r0, n_r0;
    t_point                  r_r1, n_r1;
    logic signed [SUM_W-1:0] r_sum_x, n_sum_x;
    logic signed [SUM_W-1:0] r_sum_y, n_sum_y;

    t_point                  v;
    logic                    accept;
    logic                    in_range;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [SUM_W-1:0] sum_x_add, sum_y_add;

    assign v.x    = i_vertex.vertex_x;
    assign v.y    = i_vertex.vertex_y;
    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    always_comb begin
        in_range  = (r_count < MAX_C);
        cnt_inc   = (r_count <= MAX_C) ? r_count + CNT_W'(1) : r_count;
        sum_x_add = r_sum_x + {{(SUM_W - COORD_BITS){v.x[COORD_BITS-1]}}, v.x};
        sum_y_add = r_sum_y + {{(SUM_W - COORD_BITS){v.y[COORD_BITS-1]}}, v.y};

        n_count = r_count;
        n_f0    = r_f0;
        n_f1    = r_f1;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;

        o_q_push        = 1'b0;
        o_q_cmd         = '0;
        o_q_cmd.op      = OP_ACC;
        o_q_cmd.status  = ST_OK;
        o_q_cmd.pa      = r_r0;
        o_q_cmd.pb      = r_r1;
        o_q_cmd.pv      = v;
        o_q_cmd.f0      = r_f0;
        o_q_cmd.f1      = r_f1;
        o_q_cmd.sum_x   = sum_x_add;
        o_q_cmd.sum_y   = sum_y_add;
        o_q_cmd.n       = NCNT_W'(cnt_inc);
        o_q_cmd.do_turn = (r_count >= CNT_W'(2));
        o_q_cmd.do_shoe = 1'b1;

        if (accept) begin
            if (in_range) begin
                if (r_count == '0) begin
                    n_f0 = v;
                end
                if (r_count == CNT_W'(1)) begin
                    n_f1 = v;
                end
                n_r0    = r_r1;
                n_r1    = v;
                n_sum_x = sum_x_add;
                n_sum_y = sum_y_add;
            end
            n_count = cnt_inc;

            if (i_vertex.is_last) begin
                o_q_push = 1'b1;
                if (cnt_inc < CNT_W'(3)) begin
                    o_q_cmd.op     = OP_ERR;
                    o_q_cmd.status = ST_FEW;
                end else if (cnt_inc > MAX_C) begin
                    o_q_cmd.op     = OP_ERR;
                    o_q_cmd.status = ST_MANY;
                end else begin
                    o_q_cmd.op = OP_CLOSE;
                end
                // polygon closed, start over
                n_count = '0;
                n_f0    = '0;
                n_f1    = '0;
                n_r0    = '0;
                n_r1    = '0;
                n_sum_x = '0;
                n_sum_y = '0;
            end else if (in_range && (r_count != '0)) begin
                o_q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_f0    <= '0;
            r_f1    <= '0;
            r_r0    <= '0;
            r_r1    <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else begin
            r_count <= n_count;
            r_f0    <= n_f0;
            r_f1    <= n_f1;
            r_r0    <= n_r0;
            r_r1    <= n_r1;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
        end
    end

endmodule

// ----- rtl/pvc_div.sv -----
// ----------------------------------------------------------------------------
// pvc_div
// Bit-serial restoring divider: signed coordinate sum by vertex count,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pvc_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [pvc_pkg::SUM_W-1:0]       i_dividend,
    input  logic [pvc_pkg::NCNT_W-1:0]             i_divisor,
    output logic                                   o_busy,
    output logic signed [pvc_pkg::COORD_BITS-1:0]  o_quotient
);
    import pvc_pkg::*;

    localparam int DCW = $clog2(SUM_W + 1);

    logic              r_busy, n_busy;
    logic [DCW-1:0]    r_cnt, n_cnt;
    logic [NCNT_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0]  r_q, n_q;
    logic [NCNT_W-1:0] r_div, n_div;
    logic              r_neg, n_neg;

    logic [NCNT_W:0]     trial;
    logic [NCNT_W:0]     trial_sub;
    logic [COORD_BITS-1:0] q_mag;

    assign o_busy     = r_busy;
    assign q_mag      = r_q[COORD_BITS-1:0];
    assign o_quotient = r_neg ? -q_mag : q_mag;

    always_comb begin
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_q       = r_q;
        n_div     = r_div;
        n_neg     = r_neg;
        trial     = {r_rem, r_q[SUM_W-1]};
        trial_sub = trial - {1'b0, r_div};

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DCW'(SUM_W);
            n_rem  = '0;
            n_div  = i_divisor;
            n_neg  = i_dividend[SUM_W-1];
            n_q    = i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
        end else if (r_busy) begin
            // one quotient bit per cycle
            if (trial >= {1'b0, r_div}) begin
                n_rem = trial_sub[NCNT_W-1:0];
                n_q   = {r_q[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[NCNT_W-1:0];
                n_q   = {r_q[SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - DCW'(1);
            if (r_cnt == DCW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_div <= n_div;
        r_neg <= n_neg;
    end

endmodule

// ----- rtl/pvc_back.sv -----
// ----------------------------------------------------------------------------
// pvc_back
// Arithmetic back part: turn and shoelace pipeline, closing sequence,
// centroid division and the result register.
// ----------------------------------------------------------------------------
module pvc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  pvc_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output pvc_pkg::t_result o_result
);
    import pvc_pkg::*;

    t_bstate r_state, n_state;
    t_uop    r_uop, n_uop;

    // product stage
    logic                      r_pvld;
    logic signed [TPROD_W-1:0] r_ta, r_tb;
    logic signed [SPROD_W-1:0] r_sa, r_sb;
    logic                      r_p_turn, r_p_shoe, r_p_t0;

    // accumulators
    logic signed [SHOE_W-1:0]  r_shoe, n_shoe;
    logic                      r_pos, n_pos;
    logic                      r_neg, n_neg;
    logic                      r_ccw, n_ccw;

    t_result r_res, n_res;
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;

    logic signed [DIFF_W-1:0] d1x, d1y, d2x, d2y;
    logic signed [TURN_W-1:0] turn;
    logic signed [SHOE_W-1:0] shoe_abs;
    logic                     div_start;
    logic                     busy_x, busy_y;
    logic signed [COORD_BITS-1:0] quot_x, quot_y;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    pvc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_q_cmd.sum_x),
        .i_divisor  (i_q_cmd.n),
        .o_busy     (busy_x),
        .o_quotient (quot_x)
    );

    pvc_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_q_cmd.sum_y),
        .i_divisor  (i_q_cmd.n),
        .o_busy     (busy_y),
        .o_quotient (quot_y)
    );

    // product stage operands
    always_comb begin
        d1x = diff_of(r_uop.b.x, r_uop.a.x);
        d1y = diff_of(r_uop.b.y, r_uop.a.y);
        d2x = diff_of(r_uop.c.x, r_uop.b.x);
        d2y = diff_of(r_uop.c.y, r_uop.b.y);
    end

    always_ff @(posedge i_clk) begin
        r_ta     <= d1x * d2y;
        r_tb     <= d1y * d2x;
        r_sa     <= r_uop.b.x * r_uop.c.y;
        r_sb     <= r_uop.c.x * r_uop.b.y;
        r_p_turn <= r_uop.do_turn;
        r_p_shoe <= r_uop.do_shoe;
        r_p_t0   <= r_uop.is_t0;
    end

    // sequencer, accumulate stage and result building
    always_comb begin
        n_state     = r_state;
        n_uop       = '0;
        o_q_pop     = 1'b0;
        div_start   = 1'b0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_shoe      = r_shoe;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_ccw       = r_ccw;

        turn     = TURN_W'(r_ta) - TURN_W'(r_tb);
        shoe_abs = r_shoe[SHOE_W-1] ? -r_shoe : r_shoe;

        if (r_pvld) begin
            if (r_p_turn) begin
                if (!turn[TURN_W-1] && (turn != '0)) begin
                    n_pos = 1'b1;
                end
                if (turn[TURN_W-1]) begin
                    n_neg = 1'b1;
                end
            end
            if (r_p_t0) begin
                n_ccw = !turn[TURN_W-1] && (turn != '0);
            end
            if (r_p_shoe) begin
                n_shoe = r_shoe + SHOE_W'(r_sa) - SHOE_W'(r_sb);
            end
        end

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BS_RUN: begin
                if (!i_q_empty) begin
                    case (i_q_cmd.op)
                        OP_ACC: begin
                            n_uop.valid   = 1'b1;
                            n_uop.a       = i_q_cmd.pa;
                            n_uop.b       = i_q_cmd.pb;
                            n_uop.c       = i_q_cmd.pv;
                            n_uop.do_turn = i_q_cmd.do_turn;
                            n_uop.do_shoe = i_q_cmd.do_shoe;
                            o_q_pop       = 1'b1;
                        end
                        OP_CLOSE: begin
                            n_uop.valid   = 1'b1;
                            n_uop.a       = i_q_cmd.pa;
                            n_uop.b       = i_q_cmd.pb;
                            n_uop.c       = i_q_cmd.pv;
                            n_uop.do_turn = i_q_cmd.do_turn;
                            n_uop.do_shoe = i_q_cmd.do_shoe;
                            n_state       = BS_C1;
                        end
                        default: begin
                            n_state = BS_DRAIN;
                        end
                    endcase
                end
            end
            BS_C1: begin
                // closing turn at the last vertex and closing shoelace term
                n_uop.valid   = 1'b1;
                n_uop.a       = i_q_cmd.pb;
                n_uop.b       = i_q_cmd.pv;
                n_uop.c       = i_q_cmd.f0;
                n_uop.do_turn = 1'b1;
                n_uop.do_shoe = 1'b1;
                n_state       = BS_C2;
            end
            BS_C2: begin
                // turn at vertex zero sets the direction
                n_uop.valid   = 1'b1;
                n_uop.a       = i_q_cmd.pv;
                n_uop.b       = i_q_cmd.f0;
                n_uop.c       = i_q_cmd.f1;
                n_uop.do_turn = 1'b1;
                n_uop.is_t0   = 1'b1;
                n_state       = BS_DRAIN;
            end
            BS_DRAIN: begin
                if (!r_uop.valid && !r_pvld) begin
                    n_res.status      = i_q_cmd.status;
                    n_res.is_convex   = 1'b0;
                    n_res.double_area = '0;
                    n_res.centre_x    = '0;
                    n_res.centre_y    = '0;
                    if (i_q_cmd.op == OP_CLOSE) begin
                        n_res.is_convex   = r_ccw ? !r_neg : !r_pos;
                        n_res.double_area = shoe_abs[AREA_W-1:0];
                        div_start         = 1'b1;
                        n_state           = BS_DIV;
                    end else begin
                        n_state = BS_OUT;
                    end
                    n_shoe = '0;
                    n_pos  = 1'b0;
                    n_neg  = 1'b0;
                    n_ccw  = 1'b0;
                end
            end
            BS_DIV: begin
                if (!busy_x && !busy_y) begin
                    n_res.centre_x = quot_x;
                    n_res.centre_y = quot_y;
                    n_state        = BS_OUT;
                end
            end
            BS_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    o_q_pop     = 1'b1;
                    n_state     = BS_RUN;
                end
            end
            default: begin
                n_state = BS_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_RUN;
            r_uop       <= '0;
            r_pvld      <= 1'b0;
            r_shoe      <= '0;
            r_pos       <= 1'b0;
            r_neg       <= 1'b0;
            r_ccw       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_uop       <= n_uop;
            r_pvld      <= r_uop.valid;
            r_shoe      <= n_shoe;
            r_pos       <= n_pos;
            r_neg       <= n_neg;
            r_ccw       <= n_ccw;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

// ----- rtl/polygon_convexity_area_centroid_core.sv -----
// ----------------------------------------------------------------------------
// polygon_convexity_area_centroid_core
// Polygon convexity test, doubled shoelace area and vertex-mean centroid.
// ----------------------------------------------------------------------------
// Input channel: one vertex per beat (push/full), is_last closes the polygon.
// Result channel: one result per closed polygon (empty/pop), held in an
// output register until popped.
// A front part tracks the first and recent vertices, the count and the
// coordinate sums, and sends a command for each in-range vertex after the
// first and for every closing vertex into a QUEUE_DEPTH-entry queue. The back
// part runs each command through a two-stage multiply and accumulate
// pipeline, one vertex per cycle while no closing or error command holds it.
// Interior vertices are taken one per cycle while the queue has room. A
// closing vertex holds the back part for three pipeline issues, the
// pipeline drain, the 20-step serial divider for the centroid, and the
// output load. Vertices of the next polygon keep entering while the queue
// has room; full rises when it fills.
// A stalled result (pop low) holds the back part once the next result is
// ready, and the queue then fills up behind it.
// Reset is synchronous: queue, sums, flags and the result-valid bit clear,
// and the first beat after reset starts a new polygon.
// ----------------------------------------------------------------------------
module polygon_convexity_area_centroid_core #(
    parameter int MAX_VERTICES = 8,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pvc_pkg::t_vertex i_vertex,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output pvc_pkg::t_result o_result
);
    import pvc_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_wcmd, q_rcmd;

    pvc_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_vertex (i_vertex),
        .o_full   (o_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_wcmd),
        .i_q_full (q_full)
    );

    pvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wcmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rcmd)
    );

    pvc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_rcmd),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

endmodule

// ----- rtl/pvc_checker.sv -----
// ----------------------------------------------------------------------------
// pvc_checker
// Port-level checks of the polygon core, bound to the top level.
// ----------------------------------------------------------------------------
module pvc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_full,
    input logic             o_empty,
    input logic             i_pop,
    input pvc_pkg::t_result o_result
);
    import pvc_pkg::*;

    // reset drops any waiting result
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result pending after reset");

    // reset drains the command queue
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("queue full after reset");

    // a waiting result beat holds until popped
    a_hold: assert property (@(posedge i_clk)
        (i_rst_n && !o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("result changed while stalled");

    // error results carry zero payload
    a_err_zero: assert property (@(posedge i_clk)
        (!o_empty && (o_result.status != ST_OK)) |->
        (!o_result.is_convex && (o_result.double_area == '0) &&
         (o_result.centre_x == '0) && (o_result.centre_y == '0)))
        else $error("error result with nonzero fields");

endmodule

bind polygon_convexity_area_centroid_core pvc_checker u_pvc_checker (.*);

// ----- tb/tb_polygon_convexity_area_centroid_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_convexity_area_centroid_core
// Self-checking bench for the polygon convexity / area / centroid core.
// Vertex beats go in through the push/full side and results come back
// through the empty/pop side. A behavioral tracker follows every accepted
// vertex and queues the result each closed polygon should give. A short
// table of hand-picked polygons comes first, then random polygons: convex
// shapes, random shapes, short and over-long ones, under changing idle
// rates and a long result stall.
// ----------------------------------------------------------------------------
module tb_polygon_convexity_area_centroid_core;
    import pvc_pkg::*;

    localparam int MAX_VERTS  = 8;
    localparam int RAND_ITEMS = 1126;

    typedef struct {
        t_vertex v;
        bit      typed;
        t_result want;
    } t_drow;

    logic    i_clk;
    logic    i_rst_n  = 1'b0;
    logic    i_push   = 1'b0;
    t_vertex i_vertex = '0;
    logic    i_pop    = 1'b0;
    logic    o_full;
    logic    o_empty;
    t_result o_result;

    // typed expectation that travels alongside the vertex beat
    bit      tv_typed = 1'b0;
    t_result tv_want  = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int fail_count    = 0;

    // polygon tracker state
    t_point                  first_pt[2];
    t_point                  recent_pt[2];
    logic [NCNT_W-1:0]       vcount;
    bit                      pos_turn;
    bit                      neg_turn;
    logic signed [SHOE_W-1:0] shoe_acc;
    logic signed [SUM_W-1:0] x_acc;
    logic signed [SUM_W-1:0] y_acc;

    t_result due_results[$];
    t_drow   poly_table[$];

    int OCT_X[8] = '{3, 2, 0, -2, -3, -2, 0, 2};
    int OCT_Y[8] = '{0, 2, 3, 2, 0, -2, -3, -2};

    polygon_convexity_area_centroid_core #(
        .MAX_VERTICES(MAX_VERTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_vertex(i_vertex),
        .o_full  (o_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_vertex vtx(int x, int y, bit closing);
        t_vertex v;
        v.vertex_x = x[15:0];
        v.vertex_y = y[15:0];
        v.is_last  = closing;
        return v;
    endfunction

    function automatic t_result mk_result(t_status st, bit cv, longint area, int cx, int cy);
        t_result r;
        r.status      = st;
        r.is_convex   = cv;
        r.double_area = area[35:0];
        r.centre_x    = cx[15:0];
        r.centre_y    = cy[15:0];
        return r;
    endfunction

    function automatic longint cross_turn(t_point a, t_point b, t_point c);
        longint abx, aby, bcx, bcy;
        abx = longint'(b.x) - longint'(a.x);
        aby = longint'(b.y) - longint'(a.y);
        bcx = longint'(c.x) - longint'(b.x);
        bcy = longint'(c.y) - longint'(b.y);
        return abx * bcy - aby * bcx;
    endfunction

    task automatic note_turn(input longint t);
        if (t > 0) pos_turn = 1'b1;
        if (t < 0) neg_turn = 1'b1;
    endtask

    task automatic clear_tracker();
        first_pt[0]  = '0;
        first_pt[1]  = '0;
        recent_pt[0] = '0;
        recent_pt[1] = '0;
        vcount       = '0;
        pos_turn     = 1'b0;
        neg_turn     = 1'b0;
        shoe_acc     = '0;
        x_acc        = '0;
        y_acc        = '0;
    endtask

    // fold one accepted vertex into the running polygon, queue a result on close
    task automatic track_vertex(input t_vertex vin, input bit typed, input t_result want);
        t_point  v;
        t_point  tail;
        int      k;
        longint  t0;
        longint  s;
        longint  cx;
        longint  cy;
        t_result r;
        v.x = vin.vertex_x;
        v.y = vin.vertex_y;
        k   = int'(vcount);
        if (k < MAX_VERTS) begin
            if (k == 0) begin
                first_pt[0] = v;
            end else begin
                if (k == 1) begin
                    first_pt[1] = v;
                end else begin
                    note_turn(cross_turn(recent_pt[0], recent_pt[1], v));
                end
                shoe_acc = shoe_acc + (longint'(recent_pt[1].x) * longint'(v.y)
                                       - longint'(v.x) * longint'(recent_pt[1].y));
            end
            recent_pt[0] = recent_pt[1];
            recent_pt[1] = v;
            x_acc = x_acc + v.x;
            y_acc = y_acc + v.y;
        end
        if (k <= MAX_VERTS) vcount = NCNT_W'(k + 1);

        if (vin.is_last) begin
            r = '0;
            if (vcount < 3) begin
                r.status = ST_FEW;
            end else if (vcount > MAX_VERTS) begin
                r.status = ST_MANY;
            end else begin
                tail = recent_pt[1];
                note_turn(cross_turn(recent_pt[0], tail, first_pt[0]));
                t0 = cross_turn(tail, first_pt[0], first_pt[1]);
                note_turn(t0);
                // direction comes from the turn at vertex zero
                r.status    = ST_OK;
                r.is_convex = (t0 > 0) ? !neg_turn : !pos_turn;
                s = longint'(shoe_acc) + longint'(tail.x) * longint'(first_pt[0].y)
                    - longint'(first_pt[0].x) * longint'(tail.y);
                if (s < 0) s = -s;
                r.double_area = s[35:0];
                cx = longint'(x_acc) / longint'(vcount);
                cy = longint'(y_acc) / longint'(vcount);
                r.centre_x = cx[15:0];
                r.centre_y = cy[15:0];
            end
            due_results = {due_results, (typed ? want : r)};
            clear_tracker();
        end
    endtask

    task automatic check_field(input string name, input logic signed [47:0] want,
                               input logic signed [47:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // sample both sides at the rising edge
    always @(posedge i_clk) begin : beat_monitor
        t_result want;
        if (i_rst_n) begin
            if (i_push && !o_full) track_vertex(i_vertex, tv_typed, tv_want);
            if (i_pop && !o_empty) begin
                if (due_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 48'(want.status), 48'(o_result.status));
                    check_field("is_convex", 48'(want.is_convex), 48'(o_result.is_convex));
                    check_field("double_area", 48'(want.double_area),
                                48'(o_result.double_area));
                    check_field("centre_x", want.centre_x, o_result.centre_x);
                    check_field("centre_y", want.centre_y, o_result.centre_y);
                end
            end
        end
    end

    // result side: random pop, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_pop <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_vertex(input t_vertex v, input bit typed, input t_result want);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push   <= 1'b1;
        i_vertex <= v;
        tv_typed <= typed;
        tv_want  <= want;
        do @(posedge i_clk); while (o_full);
        items_sent++;
    endtask

    function automatic int rand_coord();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            case ($urandom_range(3))
                0: return -32768;
                1: return 32767;
                2: return 0;
                default: return -1;
            endcase
        end else if (r < 4) begin
            return int'($urandom_range(200)) - 100;
        end
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic send_random_polygon();
        int       kind, n, s, ox, oy, rot, idx, sent, j;
        bit       rev;
        bit [7:0] keep;
        kind = $urandom_range(99);
        if (kind < 45) begin
            // convex: octagon corners kept in cyclic order, either direction
            n    = $urandom_range(8, 3);
            s    = $urandom_range(4000, 1);
            ox   = int'($urandom_range(40000)) - 20000;
            oy   = int'($urandom_range(40000)) - 20000;
            rot  = $urandom_range(7);
            rev  = $urandom_range(1);
            keep = 8'hFF;
            while ($countones(keep) > n) keep[$urandom_range(7)] = 1'b0;
            sent = 0;
            for (j = 0; j < 8; j++) begin
                idx = rev ? ((rot - j + 8) % 8) : ((rot + j) % 8);
                if (keep[idx]) begin
                    send_vertex(vtx(ox + s * OCT_X[idx], oy + s * OCT_Y[idx], sent == n - 1),
                                1'b0, '0);
                    sent++;
                end
            end
        end else begin
            if (kind < 80) n = $urandom_range(MAX_VERTS, 3);
            else if (kind < 90) n = $urandom_range(2, 1);
            else n = $urandom_range(MAX_VERTS + 5, MAX_VERTS + 1);
            for (j = 0; j < n; j++) begin
                send_vertex(vtx(rand_coord(), rand_coord(), j == n - 1), 1'b0, '0);
            end
        end
    endtask

    task automatic add_row(input int x, input int y, input bit closing, input bit typed,
                           input t_result want);
        t_drow row;
        row.v     = vtx(x, y, closing);
        row.typed = typed;
        row.want  = want;
        poly_table = {poly_table, row};
    endtask

    initial begin
        t_result few_res;
        t_result many_res;
        int      j;
        int      phase;

        clear_tracker();
        few_res  = mk_result(ST_FEW, 1'b0, 0, 0, 0);
        many_res = mk_result(ST_MANY, 1'b0, 0, 0, 0);

        // too few vertices
        add_row(32767, -32768, 1'b1, 1'b1, few_res);
        add_row(-32768, 32767, 1'b0, 1'b0, '0);
        add_row(-1, 0, 1'b1, 1'b1, few_res);
        // small counter-clockwise triangle
        add_row(0, 0, 1'b0, 1'b0, '0);
        add_row(4, 0, 1'b0, 1'b0, '0);
        add_row(0, 4, 1'b1, 1'b1, mk_result(ST_OK, 1'b1, 16, 1, 1));
        // full-range square, largest area
        add_row(-32768, -32768, 1'b0, 1'b0, '0);
        add_row(32767, -32768, 1'b0, 1'b0, '0);
        add_row(32767, 32767, 1'b0, 1'b0, '0);
        add_row(-32768, 32767, 1'b1, 1'b0, '0);
        // clockwise concave pentagon
        add_row(0, 0, 1'b0, 1'b0, '0);
        add_row(0, 10, 1'b0, 1'b0, '0);
        add_row(5, 3, 1'b0, 1'b0, '0);
        add_row(10, 10, 1'b0, 1'b0, '0);
        add_row(10, 0, 1'b1, 1'b0, '0);
        // one vertex past the maximum
        for (j = 0; j <= MAX_VERTS; j++) begin
            add_row(j * 1000 - 4000, (j % 2) ? -7 : 7, j == MAX_VERTS,
                    j == MAX_VERTS, many_res);
        end

        send_idle_pct = 16;
        recv_idle_pct = 61;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (poly_table[r]) send_vertex(poly_table[r].v, poly_table[r].typed,
                                            poly_table[r].want);

        items_sent = 0;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // let every result drain, then stall the result side hard
                    @(negedge i_clk);
                    i_push <= 1'b0;
                    while (due_results.size() != 0) @(posedge i_clk);
                    hold_left = 300;
                end
            endcase
            while (items_sent < (phase + 1) * RAND_ITEMS / 3) send_random_polygon();
        end

        @(negedge i_clk);
        i_push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
